FILE: src/mexp_pkg.sv
// Package for the modular exponentiation unit: field widths, register
// indexes, controller state type and the command/status bundles.
// No dependencies.
package mexp_pkg;

    localparam int BASE_W    = 64;
    localparam int EXP_W     = 32;
    localparam int MODREG_W  = 32;
    localparam int RES_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // Counter must hold the base width (reduction length) and any modulus width.
    localparam int CNT_W        = 7;
    localparam int REDUCE_STEPS = BASE_W;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_EXPONENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MODULUS  = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT_BIT,
        ST_MUL_RES,
        ST_PREP_SQR,
        ST_MUL_SQR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic mul_mode;
        logic start_res;
        logic start_sqr;
        logic commit_res;
        logic commit_base;
        logic exp_shift;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic trivial;
        logic last;
        logic exp_zero;
        logic exp_lsb;
    } status_t;

endpackage

FILE: src/mexp_if.sv
// Valid/ready channel interfaces of the modular exponentiation unit.
// Depends on mexp_pkg for the payload widths.
interface mexp_req_if;
    import mexp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_rsp_if;
    import mexp_pkg::*;

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] power_result;
    logic             key_error;

    modport source (output valid, output power_result, output key_error, input ready);
    modport sink   (input valid, input power_result, input key_error, output ready);
endinterface

interface mexp_cfg_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/mexp_ctrl.sv
// Controller of the modular exponentiation unit: sequences base reduction,
// square and multiply passes and the output register handshake.
// Depends on mexp_pkg.
module mexp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  mexp_pkg::status_t  status,
    output mexp_pkg::cmd_t     cmd
);
    import mexp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.trivial ? ST_FINISH : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (status.last)
                    state_next = ST_NEXT_BIT;
            end
            ST_NEXT_BIT:
            begin
                if (status.exp_zero)
                    state_next = ST_FINISH;
                else if (status.exp_lsb)
                    state_next = ST_MUL_RES;
                else
                    state_next = ST_MUL_SQR;
            end
            ST_MUL_RES:
            begin
                if (status.last)
                    state_next = ST_PREP_SQR;
            end
            ST_PREP_SQR:
            begin
                state_next = ST_MUL_SQR;
            end
            ST_MUL_SQR:
            begin
                if (status.last)
                    state_next = ST_NEXT_BIT;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_REDUCE:
            begin
                cmd.step        = 1'b1;
                cmd.commit_base = status.last;
            end
            ST_NEXT_BIT:
            begin
                cmd.start_res = !status.exp_zero && status.exp_lsb;
                cmd.start_sqr = !status.exp_zero && !status.exp_lsb;
            end
            ST_MUL_RES:
            begin
                cmd.step       = 1'b1;
                cmd.mul_mode   = 1'b1;
                cmd.commit_res = status.last;
            end
            ST_PREP_SQR:
            begin
                cmd.start_sqr = 1'b1;
            end
            ST_MUL_SQR:
            begin
                cmd.step        = 1'b1;
                cmd.mul_mode    = 1'b1;
                cmd.commit_base = status.last;
                cmd.exp_shift   = status.last;
            end
            ST_FINISH:
            begin
                // hold the result until the output register frees up
                cmd.publish = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid_next = cmd.publish | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result published over an unaccepted response");

    a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit_res || cmd.commit_base) |-> (cmd.step && status.last))
        else $error("commit outside the last step of a pass");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("response raised outside the finish state");
`endif

endmodule

FILE: src/mexp_datapath.sv
// Datapath of the modular exponentiation unit: key registers, a shared
// one-bit-per-cycle modular double-and-add unit and the output register.
// Depends on mexp_pkg.
module mexp_datapath #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mexp_pkg::CFG_W-1:0]     cfg_data,
    input  logic [mexp_pkg::BASE_W-1:0]    base_value,
    input  mexp_pkg::cmd_t                 cmd,
    output mexp_pkg::status_t              status,
    output logic [mexp_pkg::RES_W-1:0]     power_result,
    output logic                           key_error
);
    import mexp_pkg::*;

    localparam int MW = MOD_WIDTH;

    logic [EXP_W-1:0]    exp_key_reg;
    logic [MODREG_W-1:0] mod_key_reg;
    logic [MW-1:0]       mod_eff;

    logic [MW-1:0]     acc_reg,   acc_next;
    logic [MW-1:0]     base_reg,  base_next;
    logic [MW-1:0]     res_reg,   res_next;
    logic [BASE_W-1:0] opb_reg,   opb_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [EXP_W-1:0]  exp_reg,   exp_next;
    logic [RES_W-1:0]  power_reg, power_next;
    logic              err_reg,   err_next;

    logic [MW-1:0]     dbl_val;
    logic [MW-1:0]     step_val;
    logic [BASE_W-1:0] res_wide;

    // (x + y + cin) mod m for x, y below m
    function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] x,
                                              input logic [MW-1:0] y,
                                              input logic          cin,
                                              input logic [MW-1:0] m);
        logic [MW:0] s;
        s = {1'b0, x} + {1'b0, y} + {{MW{1'b0}}, cin};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[MW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_key_reg <= '0;
            mod_key_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_EXPONENT: exp_key_reg <= cfg_data;
                REG_KEY_MODULUS:  mod_key_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign mod_eff = MW'(mod_key_reg);

    // Reduction shifts base bits in as carry; multiply adds the base on a set bit.
    assign dbl_val  = add_mod(acc_reg, acc_reg, cmd.mul_mode ? 1'b0 : opb_reg[BASE_W-1],
                              mod_eff);
    assign step_val = (cmd.mul_mode && opb_reg[BASE_W-1]) ?
                      add_mod(dbl_val, base_reg, 1'b0, mod_eff) : dbl_val;

    assign res_wide = BASE_W'(res_reg);

    always_comb
    begin
        acc_next   = acc_reg;
        base_next  = base_reg;
        res_next   = res_reg;
        opb_next   = opb_reg;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        power_next = power_reg;
        err_next   = err_reg;

        if (cmd.load)
        begin
            acc_next = '0;
            opb_next = base_value;
            cnt_next = CNT_W'(REDUCE_STEPS);
            exp_next = exp_key_reg;
            res_next = status.trivial ? '0 : MW'(1);
        end
        if (cmd.start_res)
        begin
            acc_next = '0;
            opb_next = BASE_W'(res_reg) << (BASE_W - MW);
            cnt_next = CNT_W'(MW);
        end
        if (cmd.start_sqr)
        begin
            acc_next = '0;
            opb_next = BASE_W'(base_reg) << (BASE_W - MW);
            cnt_next = CNT_W'(MW);
        end
        if (cmd.step)
        begin
            acc_next = step_val;
            opb_next = opb_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.commit_res)
            res_next = step_val;
        if (cmd.commit_base)
            base_next = step_val;
        if (cmd.exp_shift)
            exp_next = exp_reg >> 1;
        if (cmd.publish)
        begin
            power_next = res_wide[RES_W-1:0];
            err_next   = (mod_eff == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        res_reg   <= res_next;
        opb_reg   <= opb_next;
        cnt_reg   <= cnt_next;
        exp_reg   <= exp_next;
        power_reg <= power_next;
        err_reg   <= err_next;
    end

    assign status.trivial  = (mod_eff[MW-1:1] == '0);
    assign status.last     = (cnt_reg == CNT_W'(1));
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];

    assign power_result = power_reg;
    assign key_error    = err_reg;

`ifndef SYNTH
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (acc_reg < mod_eff))
        else $error("accumulator left the residue range");

    a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_base |=> (base_reg < mod_eff))
        else $error("committed base not reduced");

    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_res |=> (res_reg < mod_eff))
        else $error("committed result not reduced");
`endif

endmodule

FILE: src/modular_exponentiation_unit.sv
// Requests with a modulus of 0 or 1 skip straight to the response; otherwise the unit
// reduces the base, then runs one multiply pass per set exponent bit and one square pass
// per exponent bit up to and including the top set bit.
// One request at a time, through the shared bit-serial modular multiplier (one bit/cycle).
// The response register frees the request side while a response waits.
// Reset: asynchronous, active low; clears key registers to 0, controller to idle.
module modular_exponentiation_unit #(
    parameter int MOD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    mexp_req_if.sink    req,
    mexp_rsp_if.source  rsp,
    mexp_cfg_if.sink    cfg
);
    import mexp_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid & cfg.ready;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mexp_datapath #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .base_value   (req.base_value),
        .cmd          (cmd),
        .status       (status),
        .power_result (rsp.power_result),
        .key_error    (rsp.key_error)
    );

endmodule

FILE: sim/modular_exponentiation_unit_tb.sv
// Testbench for modular_exponentiation_unit: drives bases and key writes, predicts
// base ^ exponent mod modulus per request and checks every response in order.
// Depends on src/mexp_pkg.sv, src/mexp_if.sv and src/modular_exponentiation_unit.sv.
module modular_exponentiation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam int MOD_W        = 32;
    localparam int TAIL_CYCLES  = 2200;       // worst-case latency of one request
    // ~300 requests at the worst case plus stalls, taken four times over
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int RANDOM_ITEMS = 270;

    typedef struct packed {
        logic [RES_W-1:0] power_result;
        logic             key_error;
    } power_rsp_t;

    class power_scoreboard;
        logic [EXP_W-1:0]    key_exponent;
        logic [MODREG_W-1:0] key_modulus;
        power_rsp_t          pending_q[$];
        int unsigned         requests;
        int unsigned         checked;
        int unsigned         key_faults;
        int unsigned         errors;

        function new();
            key_exponent = '0;
            key_modulus  = '0;
            requests     = 0;
            checked      = 0;
            key_faults   = 0;
            errors       = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] index,
                                   input logic [CFG_W-1:0] data);
            if (index == REG_KEY_EXPONENT)
                key_exponent = data;
            else if (index == REG_KEY_MODULUS)
                key_modulus = data;
        endfunction

        // Right-to-left square and multiply on exact double-width products.
        function power_rsp_t expected_power(input logic [BASE_W-1:0] base_value);
            logic [63:0]      modulus;
            logic [63:0]      sqr;
            logic [63:0]      acc;
            logic [EXP_W-1:0] bits;
            power_rsp_t       rsp;
            modulus = 64'(key_modulus) & ((MOD_W >= 64) ? '1 : ((64'd1 << MOD_W) - 1));
            rsp.key_error    = (modulus == 0);
            rsp.power_result = '0;
            if (modulus > 1)
            begin
                sqr  = base_value % modulus;
                acc  = 64'd1;
                bits = key_exponent;
                while (bits != 0)
                begin
                    if (bits[0])
                        acc = 64'((128'(acc) * sqr) % modulus);
                    sqr  = 64'((128'(sqr) * sqr) % modulus);
                    bits = bits >> 1;
                end
                rsp.power_result = acc[RES_W-1:0];
            end
            return rsp;
        endfunction

        function void note_request(input logic [BASE_W-1:0] base_value);
            pending_q.push_back(expected_power(base_value));
            requests++;
        endfunction

        function void check_response(input logic [RES_W-1:0] power_result,
                                     input logic key_error);
            power_rsp_t want;
            if (pending_q.size() == 0)
            begin
                $error("unexpected response: power_result=%h key_error=%b",
                       power_result, key_error);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (power_result !== want.power_result)
            begin
                $error("power_result mismatch: expected %h, actual %h",
                       want.power_result, power_result);
                errors++;
            end
            if (key_error !== want.key_error)
            begin
                $error("key_error mismatch: expected %b, actual %b", want.key_error, key_error);
                errors++;
            end
            checked++;
            if (want.key_error)
                key_faults++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int unsigned cycles;
    int unsigned key_settings;
    power_scoreboard sb;

    mexp_req_if req_ch();
    mexp_rsp_if rsp_ch();
    mexp_cfg_if cfg_ch();

    modular_exponentiation_unit #(
        .MOD_WIDTH(MOD_W)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch),
        .cfg  (cfg_ch)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 32);
    endfunction

    always @(posedge clk)
        rsp_ch.ready <= !take_gap();

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.power_result, rsp_ch.key_error);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Leave cfg valid high on return; the caller drops it once the burst is done.
    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] index,
                                 input logic [CFG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_register(index, data);
    endtask

    // Write both key registers once every response of the previous setting is back.
    task automatic load_key(input logic [EXP_W-1:0] exponent,
                            input logic [MODREG_W-1:0] modulus);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        write_key_reg(REG_KEY_EXPONENT, exponent);
        write_key_reg(REG_KEY_MODULUS, modulus);
        cfg_ch.valid <= 1'b0;
        key_settings++;
    endtask

    task automatic send_bases(input logic [BASE_W-1:0] bases[$]);
        foreach (bases[i])
        begin
            while (take_gap())
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
            req_ch.valid      <= 1'b1;
            req_ch.base_value <= bases[i];
            do @(posedge clk); while (!req_ch.ready);
            sb.note_request(bases[i]);
        end
        req_ch.valid <= 1'b0;
    endtask

    function automatic logic [BASE_W-1:0] random_base(input logic [MODREG_W-1:0] modulus);
        case ($urandom_range(7))
            0: return '1;
            1: return BASE_W'($urandom_range(3));
            2: return BASE_W'(modulus) - 1;
            3: return {$urandom(), 32'h0};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    initial
    begin
        logic [BASE_W-1:0]   bases[$];
        logic [EXP_W-1:0]    exponent;
        logic [MODREG_W-1:0] modulus;
        int                  phase;
        int                  count;

        sb = new();
        steady = 1'b0;
        key_settings = 0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.base_value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_KEY_EXPONENT;
        cfg_ch.data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keys straight out of reset: zero modulus flags an error.
        bases = '{64'h0, '1};
        send_bases(bases);
        load_key('1, 32'h0);
        bases = '{64'h0123_4567_89AB_CDEF};
        send_bases(bases);
        // Modulus of one always gives zero.
        load_key($urandom(), 32'h1);
        bases = '{64'h0, '1};
        send_bases(bases);
        // Zero exponent gives one, even for a zero base.
        load_key(32'h0, 32'hFFFF_FFFF);
        bases = '{64'h0, '1};
        send_bases(bases);
        // Largest key; bases at and above the modulus get reduced first.
        load_key('1, 32'hFFFF_FFFF);
        bases = '{64'h0, 64'h1, '1, 64'h0000_0001_0000_0000, 64'hFFFF_FFFF_0000_0000};
        send_bases(bases);
        // Prime modulus with exponent p-1: one for any base not divisible by p.
        load_key(32'hFFFF_FFFA, 32'hFFFF_FFFB);
        bases = '{64'h2, 64'h8000_0000_0000_0000, 64'hFFFF_FFFB};
        send_bases(bases);
        load_key(32'h1, 32'h2);
        bases = '{64'h3, 64'hFFFF_FFFF_FFFF_FFFE};
        send_bases(bases);
        load_key(32'h8000_0000, 32'h8000_0001);
        bases = '{64'h3, '1};
        send_bases(bases);

        // Random keys; most exponents short to keep the run quick, a quarter full width.
        phase = 0;
        while (sb.requests < RANDOM_ITEMS + 19)
        begin
            phase++;
            steady = (phase == 3 || phase == 4);
            case ($urandom_range(19))
                0: modulus = 32'h0;
                1: modulus = 32'h1;
                2, 3, 4, 5, 6, 7: modulus = $urandom() >> $urandom_range(1, 30);
                8, 9: modulus = 32'hFFFF_FFFF - $urandom_range(8);
                default: modulus = $urandom();
            endcase
            if ($urandom_range(3) == 0)
                exponent = $urandom();
            else
                exponent = $urandom() >> $urandom_range(20, 32);
            count = (modulus < 2) ? $urandom_range(3, 6) : $urandom_range(12, 28);
            if (steady)
                count = 30;
            bases.delete();
            repeat (count)
                bases.push_back(random_base(modulus));
            load_key(exponent, modulus);
            send_bases(bases);
        end
        steady = 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d responses checked over %0d key settings, %0d with a key error",
                 sb.checked, key_settings, sb.key_faults);
        if (sb.pending_q.size() != 0)
        begin
            $error("%0d responses never arrived", sb.pending_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/mexp_pkg.sv
src/mexp_if.sv
src/mexp_ctrl.sv
src/mexp_datapath.sv
src/modular_exponentiation_unit.sv
sim/modular_exponentiation_unit_tb.sv
